[hdl/assert_macros.svh]
// Assertion macros used by the checker file sae_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sae_pkg.sv]
// Shared widths, caps and saturating helpers for the suffix automaton unit.
// No dependencies; used by the channel interfaces, the top level and the checker.
package sae_pkg;

  localparam int SYMBOL_W = 5;
  localparam int STATE_W  = 12;
  localparam int LEN_W    = 12;
  localparam int TALLY_W  = 16;
  localparam int TOTAL_W  = 25;

  localparam logic [LEN_W-1:0]   LEN_CAP   = '1;
  localparam logic [TALLY_W-1:0] TALLY_CAP = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = '1;

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] l);
    return (l == LEN_CAP) ? LEN_CAP : l + LEN_W'(1);
  endfunction

  function automatic logic [TALLY_W-1:0] tally_inc(input logic [TALLY_W-1:0] t);
    return (t == TALLY_CAP) ? TALLY_CAP : t + TALLY_W'(1);
  endfunction

endpackage

[hdl/sae_in_if.sv]
// Input channel of the suffix automaton unit: symbol and source state.
// Depends on sae_pkg for the field widths.
interface sae_in_if;
  import sae_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic [STATE_W-1:0]  from_state;

  modport source (output valid, output symbol, output from_state, input ready);
  modport sink   (input valid, input symbol, input from_state, output ready);
endinterface

[hdl/sae_out_if.sv]
// Result channel of the suffix automaton unit: reached state and its figures.
// Depends on sae_pkg for the field widths.
interface sae_out_if;
  import sae_pkg::*;

  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] new_state;
  logic [LEN_W-1:0]   state_length;
  logic [TALLY_W-1:0] occurrence_tally;
  logic [TOTAL_W-1:0] distinct_total;
  logic               table_full;

  modport source (output valid, output new_state, output state_length,
                  output occurrence_tally, output distinct_total, output table_full,
                  input ready);
  modport sink   (input valid, input new_state, input state_length,
                  input occurrence_tally, input distinct_total, input table_full,
                  output ready);
endinterface

[hdl/sae_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sae_ram #(
  parameter int AW = 12,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

[hdl/suffix_automaton_extend_unit.sv]
// Channel     Dir  Payload                                              Handshake
// in_ch       in   symbol, from_state                                   valid/ready
// out_ch      out  new_state, state_length, occurrence_tally,           valid/ready
//                  distinct_total, table_full
// One item at a time. A fresh state looks at its suffix links twice and clears its row;
// a clone adds a copy of the source row and a pass over the redirected links. The
// transition memory has a single read port. After reset the root row is cleared with
// in_ch.ready low. A result waits in an output register; the next item is taken while
// it waits, and only finishing that item stalls on out_ch.ready.
module suffix_automaton_extend_unit #(
  parameter int MAX_STATES = 4096,
  parameter int ALPHABET   = 26
) (
  input logic clk,
  input logic rst_n,
  sae_in_if.sink    in_ch,
  sae_out_if.source out_ch
);
  import sae_pkg::*;

  localparam int SW    = $clog2(MAX_STATES);
  localparam int SYM_W = $clog2(ALPHABET);
  localparam int CW    = $clog2(ALPHABET + 1);
  localparam int TAW   = SW + SYM_W;

  typedef enum logic [22:0] {
    S_CLR  = 23'd1 << 0,  S_IDLE = 23'd1 << 1,  S_X    = 23'd1 << 2,
    S_X2   = 23'd1 << 3,  S_XL   = 23'd1 << 4,  S_OCC  = 23'd1 << 5,
    S_LRD  = 23'd1 << 6,  S_LCK  = 23'd1 << 7,  S_LLP  = 23'd1 << 8,
    S_LLX  = 23'd1 << 9,  S_NEW  = 23'd1 << 10, S_ZCLR = 23'd1 << 11,
    S_WRD  = 23'd1 << 12, S_WNX  = 23'd1 << 13, S_SPL  = 23'd1 << 14,
    S_CP   = 23'd1 << 15, S_SRD  = 23'd1 << 16, S_SCK  = 23'd1 << 17,
    S_SLX  = 23'd1 << 18, S_SLX2 = 23'd1 << 19, S_SLX3 = 23'd1 << 20,
    S_ZLNK = 23'd1 << 21, S_FIN  = 23'd1 << 22
  } st_t;

  function automatic logic [TAW-1:0] taddr(input logic [SW-1:0] s,
                                           input logic [SYM_W-1:0] c);
    return {s, c};
  endfunction

  // control
  st_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] last_r, last_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic ov_r, ov_nxt;
  // working payload
  logic [SW-1:0] from_r, from_nxt, p_r, p_nxt, x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [SW-1:0] pstop_r, pstop_nxt, xstop_r, xstop_nxt, zlink_r, zlink_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic [LEN_W-1:0] lenfrom_r, lenfrom_nxt, lenp_r, lenp_nxt, lenx_r, lenx_nxt;
  logic need2_r, need2_nxt, direct_r, direct_nxt;
  logic [SW-1:0] rstate_r, rstate_nxt;
  logic [LEN_W-1:0] rlen_r, rlen_nxt;
  logic [TALLY_W-1:0] rtally_r, rtally_nxt;
  logic rfull_r, rfull_nxt;
  logic [STATE_W-1:0] os_r, os_nxt;
  logic [LEN_W-1:0] ol_r, ol_nxt;
  logic [TALLY_W-1:0] ot_r, ot_nxt;
  logic [TOTAL_W-1:0] otot_r, otot_nxt;
  logic of_r, of_nxt;

  // memory ports
  logic t_we, l_we, n_we, o_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [SW-1:0] t_wdata, t_rdata;
  logic [SW-1:0] l_waddr, l_raddr, l_wdata, l_rdata;
  logic [SW-1:0] n_waddr, n_raddr;
  logic [LEN_W-1:0] n_wdata, n_rdata;
  logic [SW-1:0] o_waddr, o_raddr;
  logic [TALLY_W-1:0] o_wdata, o_rdata;

  logic [CW-1:0] cnt_m1;
  logic [SW:0] need_sum;
  logic [LEN_W-1:0] lz;
  logic [TOTAL_W:0] tot_sum;

  sae_ram #(.AW(TAW), .DW(SW)) u_trans (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));
  sae_ram #(.AW(SW), .DW(SW)) u_link (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata));
  sae_ram #(.AW(SW), .DW(LEN_W)) u_len (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata));
  sae_ram #(.AW(SW), .DW(TALLY_W)) u_occ (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata));

  assign in_ch.ready             = (st_r == S_IDLE);
  assign out_ch.valid            = ov_r;
  assign out_ch.new_state        = os_r;
  assign out_ch.state_length     = ol_r;
  assign out_ch.occurrence_tally = ot_r;
  assign out_ch.distinct_total   = otot_r;
  assign out_ch.table_full       = of_r;

  assign cnt_m1   = cnt_r - CW'(1);
  assign need_sum = {1'b0, last_r} + (need2_r ? (SW+1)'(2) : (SW+1)'(1));
  assign lz       = len_inc(lenfrom_r);
  assign tot_sum  = {1'b0, total_r} + (TOTAL_W+1)'(lz - lenx_r);

  always_comb begin
    st_nxt = st_r;       cnt_nxt = cnt_r;       last_nxt = last_r;   total_nxt = total_r;
    ov_nxt = ov_r;       from_nxt = from_r;     p_nxt = p_r;         x_nxt = x_r;
    y_nxt = y_r;         z_nxt = z_r;           pstop_nxt = pstop_r; xstop_nxt = xstop_r;
    zlink_nxt = zlink_r; sym_nxt = sym_r;       lenfrom_nxt = lenfrom_r;
    lenp_nxt = lenp_r;   lenx_nxt = lenx_r;     need2_nxt = need2_r; direct_nxt = direct_r;
    rstate_nxt = rstate_r; rlen_nxt = rlen_r;   rtally_nxt = rtally_r; rfull_nxt = rfull_r;
    os_nxt = os_r;       ol_nxt = ol_r;         ot_nxt = ot_r;       otot_nxt = otot_r;
    of_nxt = of_r;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = taddr(p_r, sym_r);
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = p_r;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = p_r;
    o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = x_r;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_CLR: begin
        // clear the root row and root entries
        t_we = 1'b1; t_waddr = taddr(SW'(1), cnt_r[SYM_W-1:0]);
        l_we = 1'b1; l_waddr = SW'(1);
        n_we = 1'b1; n_waddr = SW'(1);
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ALPHABET - 1)) begin
          cnt_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          sym_nxt = SYM_W'(in_ch.symbol);
          if (in_ch.from_state == '0 || 32'(in_ch.from_state) >= MAX_STATES) begin
            from_nxt = SW'(1);
          end else begin
            from_nxt = SW'(in_ch.from_state);
          end
          if (32'(in_ch.symbol) >= ALPHABET) begin
            rstate_nxt = '0; rlen_nxt = '0; rtally_nxt = '0; rfull_nxt = 1'b0;
            st_nxt = S_FIN;
          end else begin
            st_nxt = S_X;
          end
        end
      end
      S_X: begin
        t_raddr = taddr(from_r, sym_r);
        n_raddr = from_r;
        st_nxt = S_X2;
      end
      S_X2: begin
        lenfrom_nxt = n_rdata;
        x_nxt = t_rdata;
        if (t_rdata != '0) begin
          n_raddr = t_rdata;
          st_nxt = S_XL;
        end else begin
          p_nxt = from_r;
          st_nxt = S_LRD;
        end
      end
      S_XL: begin
        lenx_nxt = n_rdata;
        if (({1'b0, lenfrom_r} + (LEN_W+1)'(1)) == {1'b0, n_rdata}) begin
          o_raddr = x_r;
          st_nxt = S_OCC;
        end else if (({1'b0, last_r} + (SW+1)'(1)) > (SW+1)'(MAX_STATES - 1)) begin
          rstate_nxt = '0; rlen_nxt = '0; rtally_nxt = '0; rfull_nxt = 1'b1;
          st_nxt = S_FIN;
        end else begin
          direct_nxt = 1'b1;
          p_nxt = from_r;
          lenp_nxt = lenfrom_r;
          st_nxt = S_SPL;
        end
      end
      S_OCC: begin
        o_we = 1'b1; o_waddr = x_r; o_wdata = tally_inc(o_rdata);
        rstate_nxt = x_r; rlen_nxt = lenx_r; rtally_nxt = tally_inc(o_rdata);
        rfull_nxt = 1'b0;
        st_nxt = S_FIN;
      end
      S_LRD: begin
        // look ahead along links for the first state with a transition
        st_nxt = S_LCK;
      end
      S_LCK: begin
        if (t_rdata == '0) begin
          p_nxt = l_rdata;
          if (l_rdata == '0) begin
            pstop_nxt = '0;
            need2_nxt = 1'b0;
            st_nxt = S_NEW;
          end else begin
            st_nxt = S_LRD;
          end
        end else begin
          pstop_nxt = p_r;
          xstop_nxt = t_rdata;
          n_raddr = p_r;
          st_nxt = S_LLP;
        end
      end
      S_LLP: begin
        lenp_nxt = n_rdata;
        n_raddr = xstop_r;
        st_nxt = S_LLX;
      end
      S_LLX: begin
        lenx_nxt = n_rdata;
        need2_nxt = (({1'b0, lenp_r} + (LEN_W+1)'(1)) != {1'b0, n_rdata});
        st_nxt = S_NEW;
      end
      S_NEW: begin
        if (need_sum > (SW+1)'(MAX_STATES - 1)) begin
          rstate_nxt = '0; rlen_nxt = '0; rtally_nxt = '0; rfull_nxt = 1'b1;
          st_nxt = S_FIN;
        end else begin
          z_nxt = last_r + SW'(1);
          last_nxt = last_r + SW'(1);
          o_we = 1'b1; o_waddr = last_r + SW'(1); o_wdata = TALLY_W'(1);
          n_we = 1'b1; n_waddr = last_r + SW'(1); n_wdata = lz;
          cnt_nxt = '0;
          st_nxt = S_ZCLR;
        end
      end
      S_ZCLR: begin
        t_we = 1'b1; t_waddr = taddr(z_r, cnt_r[SYM_W-1:0]);
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ALPHABET - 1)) begin
          cnt_nxt = '0;
          p_nxt = from_r;
          st_nxt = S_WRD;
        end
      end
      S_WRD: begin
        if (p_r == pstop_r) begin
          if (pstop_r == '0) begin
            zlink_nxt = SW'(1);
            lenx_nxt = '0;
            st_nxt = S_ZLNK;
          end else if (!need2_r) begin
            zlink_nxt = xstop_r;
            st_nxt = S_ZLNK;
          end else begin
            direct_nxt = 1'b0;
            x_nxt = xstop_r;
            st_nxt = S_SPL;
          end
        end else begin
          t_we = 1'b1; t_waddr = taddr(p_r, sym_r); t_wdata = z_r;
          l_raddr = p_r;
          st_nxt = S_WNX;
        end
      end
      S_WNX: begin
        p_nxt = l_rdata;
        st_nxt = S_WRD;
      end
      S_SPL: begin
        y_nxt = last_r + SW'(1);
        last_nxt = last_r + SW'(1);
        n_we = 1'b1; n_waddr = last_r + SW'(1); n_wdata = len_inc(lenp_r);
        cnt_nxt = '0;
        st_nxt = S_CP;
      end
      S_CP: begin
        // read entry cnt of the source row, write entry cnt-1 of the clone
        if (cnt_r < CW'(ALPHABET)) begin
          t_raddr = taddr(x_r, cnt_r[SYM_W-1:0]);
        end
        if (cnt_r != '0) begin
          t_we = 1'b1; t_waddr = taddr(y_r, cnt_m1[SYM_W-1:0]); t_wdata = t_rdata;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(ALPHABET)) begin
          cnt_nxt = '0;
          st_nxt = S_SRD;
        end
      end
      S_SRD: begin
        st_nxt = S_SCK;
      end
      S_SCK: begin
        if (t_rdata == x_r) begin
          t_we = 1'b1; t_waddr = taddr(p_r, sym_r); t_wdata = y_r;
          p_nxt = l_rdata;
          st_nxt = (l_rdata == '0) ? S_SLX : S_SRD;
        end else begin
          st_nxt = S_SLX;
        end
      end
      S_SLX: begin
        l_raddr = x_r;
        st_nxt = S_SLX2;
      end
      S_SLX2: begin
        l_we = 1'b1; l_waddr = y_r; l_wdata = l_rdata;
        st_nxt = S_SLX3;
      end
      S_SLX3: begin
        l_we = 1'b1; l_waddr = x_r; l_wdata = y_r;
        o_we = 1'b1; o_waddr = y_r; o_wdata = direct_r ? TALLY_W'(1) : '0;
        if (direct_r) begin
          rstate_nxt = y_r; rlen_nxt = len_inc(lenp_r); rtally_nxt = TALLY_W'(1);
          rfull_nxt = 1'b0;
          st_nxt = S_FIN;
        end else begin
          zlink_nxt = y_r;
          lenx_nxt = len_inc(lenp_r);
          st_nxt = S_ZLNK;
        end
      end
      S_ZLNK: begin
        l_we = 1'b1; l_waddr = z_r; l_wdata = zlink_r;
        if (lz > lenx_r) begin
          total_nxt = (tot_sum > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : tot_sum[TOTAL_W-1:0];
        end
        rstate_nxt = z_r; rlen_nxt = lz; rtally_nxt = TALLY_W'(1); rfull_nxt = 1'b0;
        st_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          os_nxt = STATE_W'(rstate_r);
          ol_nxt = rlen_r;
          ot_nxt = rtally_r;
          otot_nxt = total_r;
          of_nxt = rfull_r;
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cnt_r <= '0;
      last_r <= SW'(1);
      total_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      last_r <= last_nxt;
      total_r <= total_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r <= from_nxt;     p_r <= p_nxt;           x_r <= x_nxt;
    y_r <= y_nxt;           z_r <= z_nxt;           pstop_r <= pstop_nxt;
    xstop_r <= xstop_nxt;   zlink_r <= zlink_nxt;   sym_r <= sym_nxt;
    lenfrom_r <= lenfrom_nxt; lenp_r <= lenp_nxt;   lenx_r <= lenx_nxt;
    need2_r <= need2_nxt;   direct_r <= direct_nxt;
    rstate_r <= rstate_nxt; rlen_r <= rlen_nxt;     rtally_r <= rtally_nxt;
    rfull_r <= rfull_nxt;
    os_r <= os_nxt;         ol_r <= ol_nxt;         ot_r <= ot_nxt;
    otot_r <= otot_nxt;     of_r <= of_nxt;
  end
endmodule

[hdl/sae_checker.sv]
// Port-level checks for suffix_automaton_extend_unit, attached by bind.
// Depends on sae_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sae_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [sae_pkg::STATE_W-1:0] out_new_state,
  input logic [sae_pkg::LEN_W-1:0]   out_state_length,
  input logic [sae_pkg::TALLY_W-1:0] out_occurrence_tally,
  input logic [sae_pkg::TOTAL_W-1:0] out_distinct_total,
  input logic                        out_table_full
);
  import sae_pkg::*;

  // a stalled result keeps its payload
  `SAE_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_new_state) && $stable(out_state_length) &&
    $stable(out_occurrence_tally) && $stable(out_distinct_total) &&
    $stable(out_table_full), "stalled result changed")

  // one item at a time: busy right after taking one
  `SAE_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "item taken while busy")

  `SAE_ASSERT_IMP(a_full_zero, out_valid && out_table_full,
    out_new_state == '0 && out_state_length == '0 && out_occurrence_tally == '0,
    "full table result not cleared")

  // every reached state is longer than the root and has been counted
  `SAE_ASSERT_IMP(a_state_fig, out_valid && out_new_state != '0,
    !out_table_full && out_state_length != '0 && out_occurrence_tally != '0,
    "reached state with zero length or tally")
endmodule

bind suffix_automaton_extend_unit sae_checker u_sae_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_new_state        (out_ch.new_state),
  .out_state_length     (out_ch.state_length),
  .out_occurrence_tally (out_ch.occurrence_tally),
  .out_distinct_total   (out_ch.distinct_total),
  .out_table_full       (out_ch.table_full)
);
